>>> src/lsbc_pkg.sv
package lsbc_pkg;

   localparam int MAX_POINTS  = 1024;
   localparam int ADDR_W      = $clog2(MAX_POINTS);
   localparam int CNT_W       = $clog2(MAX_POINTS + 1);
   localparam int COORD_W     = 17;
   localparam int SUM_W       = 28;
   localparam int CORDIC_STEPS = 20;
   localparam int ROT_W       = 34;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [CNT_W-1:0]          count_type;

   localparam logic [2:0] REG_GAP_THRESHOLD = 3'd0;
   localparam logic [2:0] REG_MIN_RANGE     = 3'd1;
   localparam logic [2:0] REG_MAX_RANGE     = 3'd2;
   localparam logic [2:0] REG_START_ANGLE   = 3'd3;
   localparam logic [2:0] REG_ANGLE_STEP    = 3'd4;

   localparam logic [10:0] MIN_RADIUS = 11'd51;
   localparam logic [10:0] MAX_RADIUS = 11'd1536;

   // Arctangent of 2^-i in units of 2^-32 turn.
   function automatic logic [31:0] atan_of(input logic [4:0] i);
      logic [31:0] v;
      case (i)
         5'd0:  v = 32'h20000000;
         5'd1:  v = 32'h12E4051E;
         5'd2:  v = 32'h09FB385B;
         5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;
         5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;
         5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;
         5'd9:  v = 32'h00145F2F;
         5'd10: v = 32'h000A2F98;
         5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;
         5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2F9;
         5'd15: v = 32'h0000517C;
         5'd16: v = 32'h000028BE;
         5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A2F;
         5'd19: v = 32'h00000517;
         default: v = 32'h0;
      endcase
      return v;
   endfunction

endpackage

>>> src/lidar_scan_breakpoint_clustering_core.sv
// LiDAR scan breakpoint clustering core.
// req_ carries one range return per transaction: tdata is the range in
// 1/1024 m, tuser the non-finite flag and tlast marks the last beam of a scan.
// rsp_ carries one transaction per closed cluster of two points or more:
// centroid, point count and clamped radius; tlast marks the final cluster
// caused by one return.
// csr_ writes the five registers; it is always ready and takes effect at once.
// A skipped return bypasses the rotator; a valid return runs through the 20
// iteration CORDIC rotator and, when there is a previous point, the
// breakpoint squares.
// Closing a cluster runs two centroid divisions, a pass over every stored
// point through the point memories and a square root; a cluster too short
// to emit skips them.
// Points live in two 1024 entry memories with a registered read.
// Reset is synchronous; it empties the cluster, restores the register reset
// values and needs no clearing pass of the memories.
// A result waits in the output register while rsp_tready is low; the core
// keeps taking returns and only stops when a second result is ready.
module lidar_scan_breakpoint_clustering_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] range_value
   input  logic        req_tuser,   // [0] not_finite
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [16:0] center_x, [33:17] center_y,
                                    // [44:34] point_count, [55:45] radius
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   import lsbc_pkg::*;

   typedef enum logic [22:0] {
      S_IDLE     = 23'h000001,
      S_CORDIC   = 23'h000002,
      S_BRK_SQ   = 23'h000004,
      S_BRK_CMP  = 23'h000008,
      S_DECIDE   = 23'h000010,
      S_CL_START = 23'h000020,
      S_CL_DX    = 23'h000040,
      S_CL_WX    = 23'h000080,
      S_CL_DY    = 23'h000100,
      S_CL_WY    = 23'h000200,
      S_CL_RD0   = 23'h000400,
      S_CL_RDN   = 23'h000800,
      S_CL_CH    = 23'h001000,
      S_CL_CHS   = 23'h002000,
      S_W_RD     = 23'h004000,
      S_W_SQ     = 23'h008000,
      S_W_CMP    = 23'h010000,
      S_SQ_GO    = 23'h020000,
      S_SQ_W     = 23'h040000,
      S_EMIT     = 23'h080000,
      S_CL_END   = 23'h100000,
      S_ADD      = 23'h200000,
      S_POST     = 23'h400000
   } state_type;

   state_type state_ff;

   logic [15:0] gap_ff, min_ff, max_ff, start_ff;
   logic [11:0] step_ff;

   logic [15:0]      r_ff, beam_ff;
   logic             eos_ff, prev_valid_ff, brk_ff, eos_close_ff;
   coord_type        pt_x_ff, pt_y_ff, prev_x_ff, prev_y_ff;
   coord_type        cx_ff, cy_ff, first_x_ff, first_y_ff;
   count_type        held_ff, idx_ff;
   logic signed [SUM_W-1:0] sum_x_ff, sum_y_ff;
   logic [35:0]      sqx_ff, sqy_ff;
   logic [41:0]      lim_sq_ff;
   logic [36:0]      chord_ff, best_ff;

   logic             out_valid_ff;
   logic [55:0]      out_data_ff;

   logic             accept, item_ok;
   logic [15:0]      angle;
   logic [27:0]      beam_prod;
   logic             cordic_done;
   coord_type        cordic_x, cordic_y;
   logic             div_start, div_done;
   logic [SUM_W-1:0] div_dividend, div_q;
   logic signed [SUM_W-1:0] div_sum;
   logic [SUM_W-1:0] div_mag;
   coord_type        div_result;
   logic             sq_start, sq_done;
   logic [19:0]      sq_root;
   logic [38:0]      best4, m_val;
   logic [18:0]      rad_raw;
   logic [10:0]      rad;
   logic signed [17:0] bdx, bdy, cdx, cdy, wdx, wdy;
   logic [20:0]      lim;
   logic [36:0]      brk_sum, walk_sum;
   logic [45:0]      lhs;
   logic             ram_we;
   logic [ADDR_W-1:0] ram_raddr;
   count_type        held_m1;
   logic [COORD_W-1:0] rd_x, rd_y;
   logic             full;

   function automatic logic [35:0] square18(input logic signed [17:0] v);
      logic signed [35:0] w;
      w = 36'(v);
      return 36'(w * w);
   endfunction

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign item_ok    = !req_tuser && (req_tdata >= min_ff) && (req_tdata <= max_ff);
   assign beam_prod  = 28'(beam_ff) * 28'(step_ff);
   assign angle      = start_ff + beam_prod[15:0];
   assign full       = (held_ff >= count_type'(MAX_POINTS));
   assign held_m1    = held_ff - count_type'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff   <= 16'd307;
         min_ff   <= 16'd0;
         max_ff   <= 16'hFFFF;
         start_ff <= 16'h8000;
         step_ff  <= 12'd91;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_GAP_THRESHOLD: gap_ff   <= csr_data;
            REG_MIN_RANGE:     min_ff   <= csr_data;
            REG_MAX_RANGE:     max_ff   <= csr_data;
            REG_START_ANGLE:   start_ff <= csr_data;
            REG_ANGLE_STEP:    step_ff  <= csr_data[11:0];
            default: ;
         endcase
      end
   end

   lsbc_cordic u_cordic (
      .clock       (clock),
      .reset       (reset),
      .start       (accept && item_ok),
      .range_value (req_tdata),
      .angle       (angle),
      .done        (cordic_done),
      .point_x     (cordic_x),
      .point_y     (cordic_y)
   );

   // Centroid rounding: magnitude plus half the count, divided, sign restored.
   always_comb begin
      div_sum      = ((state_ff == S_CL_DY) || (state_ff == S_CL_WY)) ? sum_y_ff : sum_x_ff;
      div_mag      = div_sum[SUM_W-1] ? SUM_W'(-div_sum) : SUM_W'(div_sum);
      div_dividend = div_mag + SUM_W'(held_ff >> 1);
      div_start    = (state_ff == S_CL_DX) || (state_ff == S_CL_DY);
   end

   lsbc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (held_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign div_result = div_sum[SUM_W-1] ? -coord_type'(div_q[COORD_W-1:0])
                                        : coord_type'(div_q[COORD_W-1:0]);

   always_comb begin
      best4    = {best_ff, 2'b00};
      m_val    = (best4 > {2'b00, chord_ff}) ? best4 : {2'b00, chord_ff};
      sq_start = (state_ff == S_SQ_GO);
      rad_raw  = sq_root[19:1];
      if (rad_raw < 19'(MIN_RADIUS)) rad = MIN_RADIUS;
      else if (rad_raw > 19'(MAX_RADIUS)) rad = MAX_RADIUS;
      else rad = rad_raw[10:0];
   end

   lsbc_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .value ({1'b0, m_val}),
      .done  (sq_done),
      .root  (sq_root)
   );

   always_comb begin
      ram_we = (state_ff == S_ADD);
      if (state_ff == S_CL_RD0) ram_raddr = '0;
      else if (state_ff == S_CL_RDN) ram_raddr = held_m1[ADDR_W-1:0];
      else ram_raddr = idx_ff[ADDR_W-1:0];
   end

   lsbc_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_ram_x (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (held_ff[ADDR_W-1:0]),
      .wr_data (pt_x_ff),
      .rd_addr (ram_raddr),
      .rd_data (rd_x)
   );

   lsbc_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_ram_y (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (held_ff[ADDR_W-1:0]),
      .wr_data (pt_y_ff),
      .rd_addr (ram_raddr),
      .rd_data (rd_y)
   );

   always_comb begin
      bdx      = 18'(pt_x_ff) - 18'(prev_x_ff);
      bdy      = 18'(pt_y_ff) - 18'(prev_y_ff);
      cdx      = 18'(coord_type'(rd_x)) - 18'(first_x_ff);
      cdy      = 18'(coord_type'(rd_y)) - 18'(first_y_ff);
      wdx      = 18'(coord_type'(rd_x)) - 18'(cx_ff);
      wdy      = 18'(coord_type'(rd_y)) - 18'(cy_ff);
      lim      = ({5'd0, gap_ff} << 4) + ({5'd0, gap_ff} << 2) + {5'd0, r_ff};
      brk_sum  = {1'b0, sqx_ff} + {1'b0, sqy_ff};
      walk_sum = brk_sum;
      lhs      = ({9'd0, brk_sum} << 8) + ({9'd0, brk_sum} << 7) + ({9'd0, brk_sum} << 4);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         held_ff       <= '0;
         sum_x_ff      <= '0;
         sum_y_ff      <= '0;
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
         prev_valid_ff <= 1'b0;
         beam_ff       <= '0;
         out_valid_ff  <= 1'b0;
         eos_close_ff  <= 1'b0;
      end else begin
         if (out_valid_ff && rsp_tready && (state_ff != S_EMIT)) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  r_ff     <= req_tdata;
                  eos_ff   <= req_tlast;
                  state_ff <= item_ok ? S_CORDIC : S_POST;
               end
            end
            S_CORDIC: begin
               if (cordic_done) begin
                  pt_x_ff  <= cordic_x;
                  pt_y_ff  <= cordic_y;
                  brk_ff   <= 1'b0;
                  state_ff <= prev_valid_ff ? S_BRK_SQ : S_DECIDE;
               end
            end
            S_BRK_SQ: begin
               sqx_ff    <= square18(bdx);
               sqy_ff    <= square18(bdy);
               lim_sq_ff <= 42'(lim) * 42'(lim);
               state_ff  <= S_BRK_CMP;
            end
            S_BRK_CMP: begin
               brk_ff   <= lhs > {4'd0, lim_sq_ff};
               state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               eos_close_ff <= 1'b0;
               state_ff     <= ((prev_valid_ff && brk_ff) || full) ? S_CL_START : S_ADD;
            end
            S_CL_START: begin
               state_ff <= (held_ff >= count_type'(2)) ? S_CL_DX : S_CL_END;
            end
            S_CL_DX: state_ff <= S_CL_WX;
            S_CL_WX: begin
               if (div_done) begin
                  cx_ff    <= div_result;
                  state_ff <= S_CL_DY;
               end
            end
            S_CL_DY: state_ff <= S_CL_WY;
            S_CL_WY: begin
               if (div_done) begin
                  cy_ff    <= div_result;
                  state_ff <= S_CL_RD0;
               end
            end
            S_CL_RD0: state_ff <= S_CL_RDN;
            S_CL_RDN: begin
               first_x_ff <= coord_type'(rd_x);
               first_y_ff <= coord_type'(rd_y);
               state_ff   <= S_CL_CH;
            end
            S_CL_CH: begin
               sqx_ff   <= square18(cdx);
               sqy_ff   <= square18(cdy);
               state_ff <= S_CL_CHS;
            end
            S_CL_CHS: begin
               chord_ff <= brk_sum;
               best_ff  <= '0;
               idx_ff   <= '0;
               state_ff <= S_W_RD;
            end
            S_W_RD: state_ff <= S_W_SQ;
            S_W_SQ: begin
               sqx_ff   <= square18(wdx);
               sqy_ff   <= square18(wdy);
               state_ff <= S_W_CMP;
            end
            S_W_CMP: begin
               if (walk_sum > best_ff) begin
                  best_ff <= walk_sum;
               end
               idx_ff   <= idx_ff + count_type'(1);
               state_ff <= (idx_ff == held_m1) ? S_SQ_GO : S_W_RD;
            end
            S_SQ_GO: state_ff <= S_SQ_W;
            S_SQ_W: begin
               if (sq_done) begin
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (!out_valid_ff || rsp_tready) begin
                  out_valid_ff <= 1'b1;
                  out_data_ff  <= {rad, held_ff, cy_ff, cx_ff};
                  state_ff     <= S_CL_END;
               end
            end
            S_CL_END: begin
               held_ff  <= '0;
               sum_x_ff <= '0;
               sum_y_ff <= '0;
               if (eos_close_ff) begin
                  prev_valid_ff <= 1'b0;
                  beam_ff       <= '0;
                  state_ff      <= S_IDLE;
               end else begin
                  state_ff <= S_ADD;
               end
            end
            S_ADD: begin
               held_ff       <= held_ff + count_type'(1);
               sum_x_ff      <= sum_x_ff + SUM_W'(pt_x_ff);
               sum_y_ff      <= sum_y_ff + SUM_W'(pt_y_ff);
               prev_x_ff     <= pt_x_ff;
               prev_y_ff     <= pt_y_ff;
               prev_valid_ff <= 1'b1;
               state_ff      <= S_POST;
            end
            S_POST: begin
               beam_ff <= beam_ff + 16'd1;
               if (eos_ff) begin
                  eos_close_ff <= 1'b1;
                  state_ff     <= S_CL_START;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // A cluster closed by a breakpoint or a full buffer leaves a single point
   // behind, so a closing at end of scan in the same transaction never emits:
   // every result is the last one of its transaction.
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_valid_ff;

endmodule

>>> src/lsbc_ram.sv
module lsbc_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

>>> src/lsbc_cordic.sv
module lsbc_cordic (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [15:0]         range_value,
   input  logic [15:0]         angle,
   output logic                done,
   output lsbc_pkg::coord_type point_x,
   output lsbc_pkg::coord_type point_y
);
   import lsbc_pkg::*;

   typedef enum logic [3:0] {
      C_IDLE = 4'b0001,
      C_ROT  = 4'b0010,
      C_MUL  = 4'b0100,
      C_RND  = 4'b1000
   } cstate_type;

   localparam logic signed [ROT_W-1:0] QUARTER = 34'sd1073741824;
   localparam logic signed [ROT_W-1:0] HALF    = 34'sd2147483648;
   localparam logic signed [ROT_W-1:0] X_START = 34'sd652032874;
   localparam logic signed [50:0]      ROUND_HALF = 51'sd536870912;

   cstate_type               state_ff;
   logic signed [ROT_W-1:0]  a_ff, x_ff, y_ff;
   logic [4:0]               step_ff;
   logic                     neg_ff;
   logic [15:0]              r_ff;
   logic signed [50:0]       prod_x_ff, prod_y_ff;
   logic                     done_ff;
   coord_type                px_ff, py_ff;

   logic signed [ROT_W-1:0]  a_start, atan_s, xs, ys;
   logic signed [16:0]       r_s;
   logic signed [20:0]       rx, ry;

   function automatic coord_type sat(input logic signed [20:0] v);
      coord_type o;
      if (v < -21'sd65536) o = -17'sd65536;
      else if (v > 21'sd65535) o = 17'sd65535;
      else o = v[16:0];
      return o;
   endfunction

   always_comb begin
      a_start = {{2{angle[15]}}, angle, 16'b0};
      atan_s  = {2'b00, atan_of(step_ff)};
      xs      = neg_ff ? -x_ff : x_ff;
      ys      = neg_ff ? -y_ff : y_ff;
      r_s     = {1'b0, r_ff};
      rx      = 21'((prod_x_ff + ROUND_HALF) >>> 30);
      ry      = 21'((prod_y_ff + ROUND_HALF) >>> 30);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= (state_ff == C_RND);
         unique case (state_ff)
            C_IDLE: begin
               if (start) begin
                  r_ff    <= range_value;
                  x_ff    <= X_START;
                  y_ff    <= '0;
                  step_ff <= '0;
                  // Fold the angle into the right half plane.
                  if (a_start > QUARTER) begin
                     a_ff   <= a_start - HALF;
                     neg_ff <= 1'b1;
                  end else if (a_start < -QUARTER) begin
                     a_ff   <= a_start + HALF;
                     neg_ff <= 1'b1;
                  end else begin
                     a_ff   <= a_start;
                     neg_ff <= 1'b0;
                  end
                  state_ff <= C_ROT;
               end
            end
            C_ROT: begin
               if (a_ff >= 0) begin
                  x_ff <= x_ff - (y_ff >>> step_ff);
                  y_ff <= y_ff + (x_ff >>> step_ff);
                  a_ff <= a_ff - atan_s;
               end else begin
                  x_ff <= x_ff + (y_ff >>> step_ff);
                  y_ff <= y_ff - (x_ff >>> step_ff);
                  a_ff <= a_ff + atan_s;
               end
               step_ff <= step_ff + 5'd1;
               if (step_ff == 5'(CORDIC_STEPS - 1)) begin
                  state_ff <= C_MUL;
               end
            end
            C_MUL: begin
               prod_x_ff <= 51'(r_s) * 51'(xs);
               prod_y_ff <= 51'(r_s) * 51'(ys);
               state_ff  <= C_RND;
            end
            C_RND: begin
               px_ff    <= sat(rx);
               py_ff    <= sat(ry);
               state_ff <= C_IDLE;
            end
            default: state_ff <= C_IDLE;
         endcase
      end
   end

   assign done    = done_ff;
   assign point_x = px_ff;
   assign point_y = py_ff;

endmodule

>>> src/lsbc_div.sv
module lsbc_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [lsbc_pkg::SUM_W-1:0]   dividend,
   input  lsbc_pkg::count_type          divisor,
   output logic                         done,
   output logic [lsbc_pkg::SUM_W-1:0]   quotient
);
   import lsbc_pkg::*;

   logic              busy_ff, done_ff;
   logic [4:0]        cnt_ff;
   logic [SUM_W-1:0]  q_ff;
   logic [CNT_W:0]    rem_ff;
   count_type         d_ff;
   logic [CNT_W:0]    trial;

   assign trial = {rem_ff[CNT_W-1:0], q_ff[SUM_W-1]};

   // Restoring division, one quotient bit per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= !start && busy_ff && (cnt_ff == 5'(SUM_W - 1));
         if (start) begin
            busy_ff <= 1'b1;
            q_ff    <= dividend;
            rem_ff  <= '0;
            d_ff    <= divisor;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            if (trial >= {1'b0, d_ff}) begin
               rem_ff <= trial - {1'b0, d_ff};
               q_ff   <= {q_ff[SUM_W-2:0], 1'b1};
            end else begin
               rem_ff <= trial;
               q_ff   <= {q_ff[SUM_W-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'(SUM_W - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

>>> src/lsbc_isqrt.sv
module lsbc_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [39:0] value,
   output logic        done,
   output logic [19:0] root
);
   import lsbc_pkg::*;

   logic        busy_ff, done_ff;
   logic [4:0]  cnt_ff;
   logic [39:0] v_ff;
   logic [21:0] rem_ff;
   logic [19:0] root_ff;
   logic [21:0] shifted, test;

   assign shifted = {rem_ff[19:0], v_ff[39:38]};
   assign test    = {root_ff, 2'b01};

   // Two radicand bits per cycle, one root bit per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= !start && busy_ff && (cnt_ff == 5'd19);
         if (start) begin
            busy_ff <= 1'b1;
            v_ff    <= value;
            rem_ff  <= '0;
            root_ff <= '0;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            v_ff <= {v_ff[37:0], 2'b00};
            if (shifted >= test) begin
               rem_ff  <= shifted - test;
               root_ff <= {root_ff[18:0], 1'b1};
            end else begin
               rem_ff  <= shifted;
               root_ff <= {root_ff[18:0], 1'b0};
            end
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd19) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

import lsbc_pkg::*;

class cluster_scoreboard;
   typedef struct {
      logic signed [16:0] center_x;
      logic signed [16:0] center_y;
      logic [10:0]        point_count;
      logic [10:0]        radius;
      logic               last_result;
   } cluster_type;

   cluster_type expected[$];
   int errors;
   int clusters_seen;
   int returns_noted;

   bit [15:0] gap_threshold, min_range, max_range, start_angle;
   bit [11:0] angle_step;
   longint    px_store[MAX_POINTS];
   longint    py_store[MAX_POINTS];
   int        points_held;
   longint    prev_x, prev_y;
   bit        prev_valid;
   bit [15:0] beam_index;
   longint    sum_x, sum_y;

   function new();
      gap_threshold = 307;
      min_range     = 0;
      max_range     = 16'hFFFF;
      start_angle   = 16'h8000;
      angle_step    = 91;
      points_held   = 0;
      prev_x        = 0;
      prev_y        = 0;
      prev_valid    = 0;
      beam_index    = 0;
      sum_x         = 0;
      sum_y         = 0;
      errors        = 0;
      clusters_seen = 0;
      returns_noted = 0;
   endfunction

   function void set_register(logic [2:0] index, logic [15:0] value);
      case (index)
         REG_GAP_THRESHOLD: gap_threshold = value;
         REG_MIN_RANGE:     min_range = value;
         REG_MAX_RANGE:     max_range = value;
         REG_START_ANGLE:   start_angle = value;
         REG_ANGLE_STEP:    angle_step = value[11:0];
         default: ;
      endcase
   endfunction

   function longint clamp_coord(longint v);
      if (v < -65536) return -65536;
      if (v > 65535) return 65535;
      return v;
   endfunction

   // Rotates the range vector by the beam angle with a 20 step CORDIC.
   function void beam_to_point(bit [15:0] r, bit [15:0] angle, output longint px,
                               output longint py);
      longint a, x, y, t;
      bit     flip;
      a    = longint'(angle) << 16;
      flip = 0;
      x    = 652032874;
      y    = 0;
      if (a >= 64'sh80000000) a -= 64'sh100000000;
      if (a > 64'sh40000000) begin
         a -= 64'sh80000000;
         flip = 1;
      end else if (a < -64'sh40000000) begin
         a += 64'sh80000000;
         flip = 1;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (a >= 0) begin
            t = x - (y >>> i);
            y = y + (x >>> i);
            x = t;
            a -= longint'(atan_of(5'(i)));
         end else begin
            t = x + (y >>> i);
            y = y - (x >>> i);
            x = t;
            a += longint'(atan_of(5'(i)));
         end
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      px = clamp_coord((longint'(r) * x + (64'sd1 <<< 29)) >>> 30);
      py = clamp_coord((longint'(r) * y + (64'sd1 <<< 29)) >>> 30);
   endfunction

   function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b   = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v  -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function longint rounded_mean(longint s, longint n);
      if (s >= 0) return (s + n / 2) / n;
      return -((-s + n / 2) / n);
   endfunction

   // Ends the open cluster; clusters of fewer than two points leave nothing.
   function void close_cluster();
      cluster_type     c;
      longint          cx, cy, dx, dy;
      longint unsigned span, d, widest, rad;
      if (points_held >= 2) begin
         cx   = rounded_mean(sum_x, points_held);
         cy   = rounded_mean(sum_y, points_held);
         dx   = px_store[points_held-1] - px_store[0];
         dy   = py_store[points_held-1] - py_store[0];
         span = dx * dx + dy * dy;
         widest = 0;
         for (int i = 0; i < points_held; i++) begin
            dx = px_store[i] - cx;
            dy = py_store[i] - cy;
            d  = dx * dx + dy * dy;
            if (d > widest) widest = d;
         end
         if (4 * widest > span) span = 4 * widest;
         rad = int_sqrt(span) >> 1;
         if (rad < MIN_RADIUS) rad = MIN_RADIUS;
         if (rad > MAX_RADIUS) rad = MAX_RADIUS;
         c.center_x    = cx[16:0];
         c.center_y    = cy[16:0];
         c.point_count = points_held[10:0];
         c.radius      = rad[10:0];
         c.last_result = 0;
         expected.insert(expected.size(), c);
      end
      points_held = 0;
      sum_x       = 0;
      sum_y       = 0;
   endfunction

   function void note_return(bit [15:0] r, bit not_finite, bit end_of_scan);
      int              queued;
      longint          px, py, dx, dy;
      longint unsigned dist_sq, limit;
      bit [15:0]       angle;
      queued = expected.size();
      returns_noted++;
      if (!not_finite && r >= min_range && r <= max_range) begin
         angle = start_angle + beam_index * angle_step;
         beam_to_point(r, angle, px, py);
         if (prev_valid) begin
            dx      = px - prev_x;
            dy      = py - prev_y;
            dist_sq = 400 * (dx * dx + dy * dy);
            limit   = 20 * longint'(gap_threshold) + r;
            if (dist_sq > limit * limit || points_held >= MAX_POINTS) close_cluster();
         end
         if (points_held >= MAX_POINTS) close_cluster();
         px_store[points_held] = px;
         py_store[points_held] = py;
         points_held++;
         sum_x     += px;
         sum_y     += py;
         prev_x     = px;
         prev_y     = py;
         prev_valid = 1;
      end
      beam_index++;
      if (end_of_scan) begin
         close_cluster();
         prev_valid = 0;
         beam_index = 0;
      end
      if (expected.size() > queued) expected[expected.size()-1].last_result = 1;
   endfunction

   function void check_result(logic [55:0] data, logic last);
      cluster_type c;
      if (expected.size() == 0) begin
         $error("cluster result with none expected: tdata %h", data);
         errors++;
         return;
      end
      c = expected.pop_front();
      clusters_seen++;
      if (data[16:0] !== c.center_x) begin
         $error("center_x: expected %0d, got %0d", c.center_x, $signed(data[16:0]));
         errors++;
      end
      if (data[33:17] !== c.center_y) begin
         $error("center_y: expected %0d, got %0d", c.center_y, $signed(data[33:17]));
         errors++;
      end
      if (data[44:34] !== c.point_count) begin
         $error("point_count: expected %0d, got %0d", c.point_count, data[44:34]);
         errors++;
      end
      if (data[55:45] !== c.radius) begin
         $error("radius: expected %0d, got %0d", c.radius, data[55:45]);
         errors++;
      end
      if (last !== c.last_result) begin
         $error("last_result: expected %0d, got %0d", c.last_result, last);
         errors++;
      end
   endfunction
endclass

module tb_top;

   localparam logic [2:0] REG_SPARE = 3'd7;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int SETTLE_CYCLES = 400;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [15:0] req_tdata = 0;
   logic        req_tuser = 0;
   logic        req_tlast = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [55:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [2:0]  csr_index = 0;
   logic [15:0] csr_data = 0;

   cluster_scoreboard clusters = new();
   int  cycles = 0;
   int  sent = 0;
   // 0: no idling, 1: sender idles, 2: receiver stalls, 3: both.
   int  idle_mode = 0;

   lidar_scan_breakpoint_clustering_core DUT (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) clusters.check_result(rsp_tdata, rsp_tlast);
      if (idle_mode == 2) rsp_tready <= ($urandom_range(99) >= 80);
      else if (idle_mode == 3) rsp_tready <= ($urandom_range(99) >= 22);
      else rsp_tready <= 1'b1;
   end

   task automatic write_reg(logic [2:0] index, logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      clusters.set_register(index, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_return(bit [15:0] r, bit not_finite, bit end_of_scan);
      // Idling changes every 50 transactions, so each style meets every phase.
      idle_mode = (sent / 50) % 4;
      while ((idle_mode == 1 && $urandom_range(99) < 80) ||
             (idle_mode == 3 && $urandom_range(99) < 22)) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= r;
      req_tuser  <= not_finite;
      req_tlast  <= end_of_scan;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      clusters.note_return(r, not_finite, end_of_scan);
      sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (clusters.expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Scans of smooth surfaces with jumps, plus non-finite and out-of-band noise.
   task automatic random_scans(int count, int lo, int hi);
      int total, beams, surface, k, r;
      total = 0;
      while (total < count) begin
         beams   = $urandom_range(90, 4);
         surface = $urandom_range(hi, lo);
         for (int i = 0; i < beams; i++) begin
            k = $urandom_range(99);
            if (k < 5) begin
               send_return(16'($urandom), 1'b1, i == beams - 1);
               continue;
            end
            if (k < 9) r = $urandom_range(65535);
            else if (k < 17) begin
               surface = $urandom_range(hi, lo);
               r = surface;
            end else begin
               surface = surface + $urandom_range(80) - 40;
               if (surface < lo) surface = lo;
               if (surface > hi) surface = hi;
               r = surface;
            end
            send_return(16'(r), 1'b0, i == beams - 1);
         end
         total += beams;
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed returns under the reset settings.
      send_return(16'd0, 0, 0);
      send_return(16'd0, 0, 0);
      send_return(16'd0, 0, 1);
      send_return(16'd1000, 0, 0);
      send_return(16'd1005, 0, 0);
      send_return(16'hFFFF, 1, 0);
      send_return(16'd1010, 0, 0);
      send_return(16'd30000, 0, 0);
      send_return(16'd30010, 0, 0);
      send_return(16'd5000, 0, 0);
      send_return(16'd0, 1, 1);
      send_return(16'hFFFF, 0, 0);
      send_return(16'hFFFF, 0, 1);
      send_return(16'd2000, 0, 1);
      send_return(16'd2000, 1, 1);
      send_return(16'd3000, 0, 0);
      send_return(16'd3001, 0, 0);
      send_return(16'd60000, 0, 1);
      random_scans(200, 0, 65535);
      drain();

      // No gap tolerance, a narrowed range band and the widest beam spacing.
      write_reg(REG_GAP_THRESHOLD, 16'd0);
      write_reg(REG_MIN_RANGE, 16'd500);
      write_reg(REG_MAX_RANGE, 16'd60000);
      write_reg(REG_START_ANGLE, 16'h0000);
      write_reg(REG_ANGLE_STEP, 16'd4095);
      write_reg(REG_SPARE, 16'hFFFF);
      send_return(16'd499, 0, 0);
      send_return(16'd60001, 0, 0);
      random_scans(100, 300, 62000);
      drain();

      // All beams on one ray with a huge tolerance, so the point buffer fills.
      write_reg(REG_GAP_THRESHOLD, 16'hFFFF);
      write_reg(REG_MIN_RANGE, 16'd0);
      write_reg(REG_MAX_RANGE, 16'hFFFF);
      write_reg(REG_START_ANGLE, 16'h7FFF);
      write_reg(REG_ANGLE_STEP, 16'd0);
      for (int i = 0; i < MAX_POINTS + 6; i++)
         send_return(16'(16'd1000 + $urandom_range(20)), 0, i == MAX_POINTS + 5);
      drain();

      write_reg(REG_GAP_THRESHOLD, 16'd1000);
      write_reg(REG_MIN_RANGE, 16'd100);
      write_reg(REG_MAX_RANGE, 16'd8000);
      write_reg(REG_START_ANGLE, 16'h8000);
      write_reg(REG_ANGLE_STEP, 16'd200);
      random_scans(200, 50, 8200);
      drain();

      $display("Sent %0d range returns over four register settings, including a full point buffer.",
               clusters.returns_noted);
      $display("Checked %0d clusters with %0d field mismatches.", clusters.clusters_seen,
               clusters.errors);
      if (clusters.errors == 0) $display("tb_top: PASS");
      else $display("tb_top: FAIL");
      $finish;
   end

endmodule

>>> lidar_scan_breakpoint_clustering_core.f
src/lsbc_pkg.sv
src/lsbc_ram.sv
src/lsbc_cordic.sv
src/lsbc_div.sv
src/lsbc_isqrt.sv
src/lidar_scan_breakpoint_clustering_core.sv
verif/tb_top.sv
